FILE: hw/rtl/sdg_pkg.sv
// ----------------------------------------------------------------------------
// sdg_pkg
// Shared types and constants of the stereo distance gain block.
// ----------------------------------------------------------------------------
package sdg_pkg;

	localparam int GAIN_W    = 16;
	localparam int HEAD_W    = 16;
	localparam int SCALE_W   = 16;
	localparam int CFG_IDX_W = 3;

	typedef logic [GAIN_W-1:0] gain_t;

	localparam gain_t GAIN_MAX = 16'hFFFF;
	localparam gain_t GAIN_ZERO = 16'h0000;

	// Distances are Q8.8; nothing closer than 1.0 is used.
	localparam int DIST_MIN = 256;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UP     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRONT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LISTEN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAD   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd6;

	// Spatial modes. Any other code behaves as absolute.
	localparam logic [1:0] MODE_ABS = 2'd0;
	localparam logic [1:0] MODE_REL = 2'd1;
	localparam logic [1:0] MODE_OFF = 2'd2;

endpackage

FILE: hw/rtl/sdg_stream_if.sv
// ----------------------------------------------------------------------------
// sdg_stream_if
// Sample channels of the stereo distance gain block: input and result pairs.
// ----------------------------------------------------------------------------
interface sdg_in_if #(parameter int SAMPLE_BITS = 16);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] left_in;
	logic [SAMPLE_BITS-1:0] right_in;
	logic                   block_end_in;

	modport source (output valid, output left_in, output right_in, output block_end_in,
		input ready);
	modport sink (input valid, input left_in, input right_in, input block_end_in,
		output ready);
endinterface

interface sdg_out_if #(parameter int SAMPLE_BITS = 16);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] left_out;
	logic [SAMPLE_BITS-1:0] right_out;
	logic                   block_end_out;

	modport source (output valid, output left_out, output right_out, output block_end_out,
		input ready);
	modport sink (input valid, input left_out, input right_out, input block_end_out,
		output ready);
endinterface

FILE: hw/rtl/stereo_distance_gain_top.sv
// ----------------------------------------------------------------------------
// stereo_distance_gain_top
// Scales stereo sample pairs by per-ear gains derived from source geometry.
// ----------------------------------------------------------------------------
//  Port     Direction  Contents
//  in_ch    sink       left_in, right_in, block_end_in
//  out_ch   source     left_out, right_out, block_end_out
//  cfg_*    write      cfg_we, cfg_idx (0..6), cfg_data
//
// With current gains a sample pair transfers every cycle and its result is
// registered at the transfer, so it is offered in the next cycle. A register
// write marks the gains stale; the recompute then runs before the next input
// transfer. Relative mode goes straight to the ear lanes. The recompute time is
// set by the bit-serial square roots and dividers; the three offset divisions
// dominate the absolute case. Disabled mode sets unit gains straight from idle,
// and a degenerate axis gives zero gains after the cross and magnitude states.
// After reset the gains are stale and are computed for the reset configuration.
// A stalled output holds its pair and blocks further input transfers.
module stereo_distance_gain_top #(
	parameter int SAMPLE_BITS    = 16,
	parameter int COORD_BITS     = 16,
	parameter int GAIN_FRAC_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sdg_in_if.sink                        in_ch,
	sdg_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [sdg_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [3*COORD_BITS-1:0]       cfg_data
);
	import sdg_pkg::*;

	localparam int CW   = COORD_BITS;
	localparam int VW   = 3 * CW;
	localparam int XW   = 2 * CW + 1;
	localparam int MW   = 2 * CW;
	localparam int AW   = (MW < 30) ? MW : 30;
	localparam int NSQW = 2 * AW + 2;
	localparam int NRW  = AW + 1;
	localparam int ONW  = AW + HEAD_W + 1;
	localparam int EW   = ((CW > 17) ? CW : 17) + 1;
	localparam int GF   = GAIN_FRAC_BITS;

	localparam logic [GAIN_W:0] ONE_WIDE = (GAIN_W + 1)'(1) << GF;
	localparam gain_t UNIT_GAIN = ONE_WIDE[GAIN_W] ? GAIN_MAX : ONE_WIDE[GAIN_W-1:0];

	typedef enum logic [3:0] {
		S_IDLE, S_CROSS, S_MAG, S_SHIFT, S_SUMSQ, S_NORM, S_OFSMUL, S_OFSDIV, S_LANES
	} state_t;

	// Configuration registers
	logic [1:0]         mode_q;
	logic [VW-1:0]      up_q;
	logic [VW-1:0]      front_q;
	logic [VW-1:0]      lis_q;
	logic [VW-1:0]      src_q;
	logic [HEAD_W-1:0]  head_q;
	logic [SCALE_W-1:0] scale_q;

	logic cfg_hit;
	assign cfg_hit = cfg_we && (cfg_idx <= CFG_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_OFF;
			up_q    <= '0;
			front_q <= '0;
			lis_q   <= '0;
			src_q   <= '0;
			head_q  <= HEAD_W'(256);
			scale_q <= SCALE_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_MODE:   mode_q  <= cfg_data[1:0];
				CFG_UP:     up_q    <= cfg_data;
				CFG_FRONT:  front_q <= cfg_data;
				CFG_LISTEN: lis_q   <= cfg_data;
				CFG_SOURCE: src_q   <= cfg_data;
				CFG_HEAD:   head_q  <= cfg_data[HEAD_W-1:0];
				CFG_SCALE:  scale_q <= cfg_data[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Recompute sequencer
	state_t                 state_q;
	logic                   cur_q;
	logic [1:0]             idx_q;
	logic signed [XW-1:0]   c_q [3];
	logic [MW-1:0]          a_q [3];
	logic [MW-1:0]          mx_q;
	logic [NSQW-1:0]        sum_q;
	logic [NRW-1:0]         n_q;
	logic [ONW-1:0]         onum_q;
	logic [2:0][EW-1:0]     ear_l_q;
	logic [2:0][EW-1:0]     ear_r_q;
	gain_t                  lgain_q;
	gain_t                  rgain_q;
	logic                   sqrt_go_q;
	logic                   div_go_q;
	logic                   lane_go_q;

	logic signed [CW-1:0]   ma, mb, mc, md;
	logic signed [2*CW-1:0] p1, p2;
	logic signed [XW-1:0]   cross_c;
	logic [MW-1:0]          mag_c [3];
	logic [MW-1:0]          m01, mx_c;
	logic [2*AW-1:0]        sq;
	logic signed [CW-1:0]   lp_c;
	logic signed [EW-1:0]   off_c;
	logic [EW-1:0]          el_c, er_c;
	logic signed [EW-1:0]   head_s;
	logic                   sqrt_done;
	logic [NRW-1:0]         root;
	logic                   div_done;
	logic [ONW-1:0]         quot;
	logic                   l_done, r_done;
	gain_t                  l_gain, r_gain;

	always_comb begin
		ma = '0;
		mb = '0;
		mc = '0;
		md = '0;
		unique case (idx_q)
			2'd0: begin
				ma = up_q[CW +: CW];   mb = front_q[2*CW +: CW];
				mc = up_q[2*CW +: CW]; md = front_q[CW +: CW];
			end
			2'd1: begin
				ma = up_q[2*CW +: CW]; mb = front_q[0 +: CW];
				mc = up_q[0 +: CW];    md = front_q[2*CW +: CW];
			end
			2'd2: begin
				ma = up_q[0 +: CW];    mb = front_q[CW +: CW];
				mc = up_q[CW +: CW];   md = front_q[0 +: CW];
			end
			default: begin
			end
		endcase
		p1      = ma * mb;
		p2      = mc * md;
		cross_c = XW'(p1) - XW'(p2);

		for (int i = 0; i < 3; i++) begin
			mag_c[i] = c_q[i][XW-1] ? MW'(-c_q[i]) : MW'(c_q[i]);
		end
		m01  = (mag_c[0] > mag_c[1]) ? mag_c[0] : mag_c[1];
		mx_c = (m01 > mag_c[2]) ? m01 : mag_c[2];

		sq = a_q[idx_q][AW-1:0] * a_q[idx_q][AW-1:0];

		// Ear offset has the sign of the cross product component.
		lp_c   = lis_q[idx_q*CW +: CW];
		off_c  = c_q[idx_q][XW-1] ? -EW'(quot[HEAD_W-1:0]) : EW'(quot[HEAD_W-1:0]);
		el_c   = EW'(lp_c) + off_c;
		er_c   = EW'(lp_c) - off_c;
		head_s = EW'(head_q);
	end

	sdg_isqrt #(.IW(NSQW)) u_norm_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_go_q),
		.radicand (sum_q),
		.done     (sqrt_done),
		.root     (root)
	);

	sdg_divu #(.NW(ONW), .DW(NRW)) u_norm_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (onum_q),
		.den    (n_q),
		.done   (div_done),
		.quot   (quot)
	);

	sdg_ear_lane #(.EW(EW), .CW(CW), .GF(GF)) u_lane_l (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_go_q),
		.ear    (ear_l_q),
		.src    (src_q),
		.scale  (scale_q),
		.done   (l_done),
		.gain   (l_gain)
	);

	sdg_ear_lane #(.EW(EW), .CW(CW), .GF(GF)) u_lane_r (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_go_q),
		.ear    (ear_r_q),
		.src    (src_q),
		.scale  (scale_q),
		.done   (r_done),
		.gain   (r_gain)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cur_q     <= 1'b0;
			idx_q     <= '0;
			lgain_q   <= GAIN_ZERO;
			rgain_q   <= GAIN_ZERO;
			sqrt_go_q <= 1'b0;
			div_go_q  <= 1'b0;
			lane_go_q <= 1'b0;
			mx_q      <= '0;
			sum_q     <= '0;
			n_q       <= '0;
			onum_q    <= '0;
			ear_l_q   <= '0;
			ear_r_q   <= '0;
			for (int i = 0; i < 3; i++) begin
				c_q[i] <= '0;
				a_q[i] <= '0;
			end
		end else begin
			sqrt_go_q <= 1'b0;
			div_go_q  <= 1'b0;
			lane_go_q <= 1'b0;
			if (cfg_hit) begin
				// A write restarts any recompute in flight.
				cur_q   <= 1'b0;
				state_q <= S_IDLE;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (!cur_q) begin
							priority if (mode_q == MODE_OFF) begin
								lgain_q <= UNIT_GAIN;
								rgain_q <= UNIT_GAIN;
								cur_q   <= 1'b1;
							end else if (mode_q == MODE_REL) begin
								ear_l_q   <= {EW'(0), EW'(0), -head_s};
								ear_r_q   <= {EW'(0), EW'(0), head_s};
								lane_go_q <= 1'b1;
								state_q   <= S_LANES;
							end else begin
								idx_q   <= '0;
								state_q <= S_CROSS;
							end
						end
					end
					S_CROSS: begin
						c_q[idx_q] <= cross_c;
						if (idx_q == 2'd2) begin
							state_q <= S_MAG;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					S_MAG: begin
						if (c_q[0] == '0 && c_q[1] == '0 && c_q[2] == '0) begin
							lgain_q <= GAIN_ZERO;
							rgain_q <= GAIN_ZERO;
							cur_q   <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							for (int i = 0; i < 3; i++) begin
								a_q[i] <= mag_c[i];
							end
							mx_q    <= mx_c;
							state_q <= S_SHIFT;
						end
					end
					S_SHIFT: begin
						// Bring the largest magnitude below 2^30, one bit a cycle.
						if ((mx_q >> 30) != '0) begin
							for (int i = 0; i < 3; i++) begin
								a_q[i] <= a_q[i] >> 1;
							end
							mx_q <= mx_q >> 1;
						end else begin
							idx_q   <= '0;
							sum_q   <= '0;
							state_q <= S_SUMSQ;
						end
					end
					S_SUMSQ: begin
						sum_q <= sum_q + NSQW'(sq);
						if (idx_q == 2'd2) begin
							sqrt_go_q <= 1'b1;
							state_q   <= S_NORM;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					S_NORM: begin
						if (!sqrt_go_q && sqrt_done) begin
							n_q     <= root;
							idx_q   <= '0;
							state_q <= S_OFSMUL;
						end
					end
					S_OFSMUL: begin
						onum_q   <= ONW'(a_q[idx_q][AW-1:0] * head_q) + ONW'(n_q >> 1);
						div_go_q <= 1'b1;
						state_q  <= S_OFSDIV;
					end
					S_OFSDIV: begin
						if (!div_go_q && div_done) begin
							ear_l_q[idx_q] <= el_c;
							ear_r_q[idx_q] <= er_c;
							if (idx_q == 2'd2) begin
								lane_go_q <= 1'b1;
								state_q   <= S_LANES;
							end else begin
								idx_q   <= idx_q + 1'b1;
								state_q <= S_OFSMUL;
							end
						end
					end
					S_LANES: begin
						if (!lane_go_q && l_done && r_done) begin
							lgain_q <= l_gain;
							rgain_q <= r_gain;
							cur_q   <= 1'b1;
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	// Sample path
	logic                   ov_q;
	logic [SAMPLE_BITS-1:0] lout_q;
	logic [SAMPLE_BITS-1:0] rout_q;
	logic                   bend_q;
	logic [SAMPLE_BITS-1:0] l_scaled;
	logic [SAMPLE_BITS-1:0] r_scaled;
	logic                   in_xfer;

	sdg_scale_lane #(.SB(SAMPLE_BITS), .GF(GF)) u_scale_l (
		.sample (in_ch.left_in),
		.gain   (lgain_q),
		.result (l_scaled)
	);

	sdg_scale_lane #(.SB(SAMPLE_BITS), .GF(GF)) u_scale_r (
		.sample (in_ch.right_in),
		.gain   (rgain_q),
		.result (r_scaled)
	);

	assign in_ch.ready = cur_q && (!ov_q || out_ch.ready);
	assign in_xfer     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (in_xfer) begin
			ov_q <= 1'b1;
		end else if (out_ch.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			lout_q <= l_scaled;
			rout_q <= r_scaled;
			bend_q <= in_ch.block_end_in;
		end
	end

	assign out_ch.valid         = ov_q;
	assign out_ch.left_out      = lout_q;
	assign out_ch.right_out     = rout_q;
	assign out_ch.block_end_out = bend_q;

endmodule

FILE: hw/rtl/sdg_isqrt.sv
// ----------------------------------------------------------------------------
// sdg_isqrt
// Integer square root, two radicand bits per cycle, floor result.
// ----------------------------------------------------------------------------
module sdg_isqrt #(
	parameter int IW = 50
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [IW-1:0]             radicand,
	output logic                      done,
	output logic [(IW+IW%2)/2-1:0]    root
);
	localparam int PW    = IW + IW % 2;
	localparam int RW    = PW / 2;
	localparam int CNT_W = $clog2(RW + 1);

	logic [PW-1:0]    val_q;
	logic [RW:0]      rem_q;
	logic [RW-1:0]    root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [RW+2:0] rem_sh;
	logic [RW+2:0] trial;
	logic          fits;
	logic [RW+2:0] rem_next;

	always_comb begin
		rem_sh   = {rem_q, val_q[PW-1 -: 2]};
		trial    = {1'b0, root_q, 2'b01};
		fits     = rem_sh >= trial;
		rem_next = fits ? rem_sh - trial : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				cnt_q  <= CNT_W'(RW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= PW'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			val_q  <= val_q << 2;
			rem_q  <= rem_next[RW:0];
			root_q <= {root_q[RW-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: hw/rtl/sdg_divu.sv
// ----------------------------------------------------------------------------
// sdg_divu
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sdg_divu #(
	parameter int NW = 40,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);
	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    num_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [DW:0] rem_sh;
	logic        fits;
	logic [DW:0] rem_next;

	always_comb begin
		rem_sh   = {rem_q, num_q[NW-1]};
		fits     = rem_sh >= {1'b0, den_q};
		rem_next = fits ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The quotient bits shift in where the dividend bits leave.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[NW-2:0], fits};
			rem_q <= rem_next[DW-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

FILE: hw/rtl/sdg_ear_lane.sv
// ----------------------------------------------------------------------------
// sdg_ear_lane
// One ear: distance to the source, clamp, and reciprocal gain.
// ----------------------------------------------------------------------------
module sdg_ear_lane #(
	parameter int EW = 18,
	parameter int CW = 16,
	parameter int GF = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2:0][EW-1:0]    ear,
	input  logic [3*CW-1:0]       src,
	input  logic [15:0]           scale,
	output logic                  done,
	output sdg_pkg::gain_t        gain
);
	import sdg_pkg::*;

	localparam int DFW  = EW + 1;
	localparam int SQW  = 2 * DFW + 2;
	localparam int RTW  = (SQW + SQW % 2) / 2;
	localparam int PW   = RTW + SCALE_W;
	localparam int NUMW = ((PW > GF + 17) ? PW : GF + 17) + 1;

	typedef enum logic [2:0] {L_IDLE, L_SUM, L_ROOT, L_MUL, L_CHK, L_DIV} lstate_t;

	localparam logic [NUMW-1:0] UNIT = NUMW'(1) << (GF + 16);

	lstate_t         state_q;
	logic [1:0]      idx_q;
	logic [SQW-1:0]  acc_q;
	logic [RTW-1:0]  dist_q;
	logic [PW-1:0]   prod_q;
	logic            sqrt_go_q;
	logic            div_go_q;
	logic            done_q;
	gain_t           gain_q;

	logic signed [EW-1:0]  ear_c;
	logic signed [CW-1:0]  src_c;
	logic signed [DFW-1:0] diff;
	logic [DFW-1:0]        mag;
	logic [2*DFW-1:0]      sq;
	logic                  sqrt_done;
	logic [RTW-1:0]        root;
	logic                  div_done;
	logic [NUMW-1:0]       quot;
	logic [NUMW-1:0]       num;

	always_comb begin
		ear_c = ear[idx_q];
		src_c = src[idx_q*CW +: CW];
		diff  = DFW'(ear_c) - DFW'(src_c);
		mag   = diff[DFW-1] ? ~diff + 1'b1 : diff;
		sq    = mag * mag;
		num   = UNIT + NUMW'(prod_q >> 1);
	end

	sdg_isqrt #(.IW(SQW)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_go_q),
		.radicand (acc_q),
		.done     (sqrt_done),
		.root     (root)
	);

	sdg_divu #(.NW(NUMW), .DW(PW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (num),
		.den    (prod_q),
		.done   (div_done),
		.quot   (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= L_IDLE;
			idx_q     <= '0;
			sqrt_go_q <= 1'b0;
			div_go_q  <= 1'b0;
			done_q    <= 1'b0;
			gain_q    <= GAIN_ZERO;
			acc_q     <= '0;
			dist_q    <= '0;
			prod_q    <= '0;
		end else begin
			sqrt_go_q <= 1'b0;
			div_go_q  <= 1'b0;
			done_q    <= 1'b0;
			if (start) begin
				state_q <= L_SUM;
				idx_q   <= '0;
				acc_q   <= '0;
			end else begin
				unique case (state_q)
					L_IDLE: begin
					end
					L_SUM: begin
						acc_q <= acc_q + SQW'(sq);
						if (idx_q == 2'd2) begin
							sqrt_go_q <= 1'b1;
							state_q   <= L_ROOT;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					L_ROOT: begin
						if (!sqrt_go_q && sqrt_done) begin
							dist_q  <= (root < RTW'(DIST_MIN)) ? RTW'(DIST_MIN) : root;
							state_q <= L_MUL;
						end
					end
					L_MUL: begin
						prod_q  <= dist_q * scale;
						state_q <= L_CHK;
					end
					L_CHK: begin
						// A zero distance factor gives the largest gain.
						if (prod_q == '0) begin
							gain_q  <= GAIN_MAX;
							done_q  <= 1'b1;
							state_q <= L_IDLE;
						end else begin
							div_go_q <= 1'b1;
							state_q  <= L_DIV;
						end
					end
					L_DIV: begin
						if (!div_go_q && div_done) begin
							gain_q  <= ((quot >> GAIN_W) != '0) ? GAIN_MAX : quot[GAIN_W-1:0];
							done_q  <= 1'b1;
							state_q <= L_IDLE;
						end
					end
					default: state_q <= L_IDLE;
				endcase
			end
		end
	end

	assign done = done_q;
	assign gain = gain_q;

endmodule

FILE: hw/rtl/sdg_scale_lane.sv
// ----------------------------------------------------------------------------
// sdg_scale_lane
// One channel: sample times gain, rounded and saturated.
// ----------------------------------------------------------------------------
module sdg_scale_lane #(
	parameter int SB = 16,
	parameter int GF = 12
) (
	input  logic [SB-1:0]   sample,
	input  sdg_pkg::gain_t  gain,
	output logic [SB-1:0]   result
);
	import sdg_pkg::*;

	localparam int QW = SB + GAIN_W + 2;

	localparam logic signed [QW-1:0] HI = {{(QW-SB+1){1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [QW-1:0] LO = {{(QW-SB+1){1'b1}}, {(SB-1){1'b0}}};
	localparam logic signed [QW-1:0] RND = QW'(1) << (GF - 1);

	logic signed [SB-1:0]     s;
	logic signed [GAIN_W:0]   g;
	logic signed [QW-1:0]     v;
	logic signed [QW-1:0]     q;

	always_comb begin
		s = sample;
		g = {1'b0, gain};
		v = QW'(s * g) + RND;
		// Arithmetic shift floors, which also covers the negative rounding.
		q = v >>> GF;
		if (q > HI) begin
			result = HI[SB-1:0];
		end else if (q < LO) begin
			result = LO[SB-1:0];
		end else begin
			result = q[SB-1:0];
		end
	end

endmodule
